/* design/detection_row_argmax_box_decode_unit_assert.svh */
// Assertion macros for the detection row decoder checker.
// Depends on nothing; included by the checker file only.
`ifndef DETECTION_ROW_ARGMAX_BOX_DECODE_UNIT_ASSERT_SVH
`define DETECTION_ROW_ARGMAX_BOX_DECODE_UNIT_ASSERT_SVH

// Same-cycle implication, off while reset is asserted.
`define DRD_ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("drd assertion failed");

// Next-cycle implication, off while reset is asserted.
`define DRD_ASSERT_NXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("drd assertion failed");

// Next-cycle implication that also holds through reset.
`define DRD_ASSERT_NXT_RST(lbl, clk, a, c) \
  lbl: assert property (@(posedge clk) (a) |=> (c)) \
    else $error("drd assertion failed");

`endif

/* design/drd_pkg.sv */
// Shared types and constants for the detection row decoder.
// No dependencies; imported by every module of the block.
package drd_pkg;

  localparam int unsigned VAL_W   = 16;
  localparam int unsigned PIX_W   = 12;
  localparam int unsigned CLS_W   = 7;
  localparam int unsigned POS_W   = 8;

  // Class scores beyond this count are ignored.
  localparam logic [10:0] MAX_CLASSES = 11'd128;

  // Row element positions of the box fields.
  localparam logic [POS_W-1:0] POS_CX     = 8'd0;
  localparam logic [POS_W-1:0] POS_CY     = 8'd1;
  localparam logic [POS_W-1:0] POS_W_FRAC = 8'd2;
  localparam logic [POS_W-1:0] POS_H_FRAC = 8'd3;
  localparam logic [POS_W-1:0] POS_FIRST_SCORE = 8'd4;
  localparam logic [POS_W-1:0] POS_SAT    = 8'd255;

  // Register indexes on the APB port.
  localparam logic [1:0] REG_CONF_THR = 2'd0;
  localparam logic [1:0] REG_FRAME_W  = 2'd1;
  localparam logic [1:0] REG_FRAME_H  = 2'd2;

  localparam logic [VAL_W-1:0] RST_CONF_THR = 16'd32768;
  localparam logic [PIX_W-1:0] RST_FRAME_W  = 12'd640;
  localparam logic [PIX_W-1:0] RST_FRAME_H  = 12'd480;

  // One closed row that passed the threshold.
  typedef struct packed {
    logic [CLS_W-1:0] class_idx;
    logic [VAL_W-1:0] score;
    logic [VAL_W-1:0] cx;
    logic [VAL_W-1:0] cy;
    logic [VAL_W-1:0] w_frac;
    logic [VAL_W-1:0] h_frac;
  } row_rec_t;

  // Queue status seen by the front and back parts.
  typedef struct packed {
    logic full;
    logic not_empty;
  } q_stat_t;

endpackage

/* design/drd_front.sv */
// Front part: accepts row elements, tracks box fields and running argmax.
// Depends on drd_pkg; pushes qualified rows into drd_queue.
module drd_front
  import drd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [VAL_W-1:0]     in_value,
  input  logic                 in_row_end,
  input  logic [VAL_W-1:0]     conf_thr,
  input  q_stat_t              q_stat,
  output logic                 push,
  output row_rec_t             push_rec
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [VAL_W-1:0] best_r, best_nxt;
  logic [CLS_W-1:0] bcls_r, bcls_nxt;
  logic [VAL_W-1:0] cx_r, cx_nxt, cy_r, cy_nxt, w_r, w_nxt, h_r, h_nxt;
  logic [POS_W-1:0] cls;
  logic             is_score, take, accept;
  logic [VAL_W-1:0] best_upd;
  logic [CLS_W-1:0] bcls_upd;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cx_nxt   = (pos_r == POS_CX)     ? in_value : cx_r;
    cy_nxt   = (pos_r == POS_CY)     ? in_value : cy_r;
    w_nxt    = (pos_r == POS_W_FRAC) ? in_value : w_r;
    h_nxt    = (pos_r == POS_H_FRAC) ? in_value : h_r;
    cls      = pos_r - POS_FIRST_SCORE;
    is_score = (pos_r >= POS_FIRST_SCORE) && (pos_r != POS_SAT) &&
               ({3'b000, cls} < MAX_CLASSES);
    take     = is_score && (in_value > best_r);
    best_upd = take ? in_value : best_r;
    bcls_upd = take ? cls[CLS_W-1:0] : bcls_r;

    push     = accept && in_row_end && (best_upd > conf_thr);
    push_rec = '{class_idx: bcls_upd, score: best_upd, cx: cx_nxt, cy: cy_nxt,
                 w_frac: w_nxt, h_frac: h_nxt};

    pos_nxt  = pos_r;
    best_nxt = best_r;
    bcls_nxt = bcls_r;
    if (accept) begin
      if (in_row_end) begin
        pos_nxt  = '0;
        best_nxt = '0;
      end else begin
        pos_nxt  = (pos_r == POS_SAT) ? pos_r : pos_r + 8'd1;
        best_nxt = best_upd;
        bcls_nxt = bcls_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      best_r <= '0;
    end else begin
      pos_r  <= pos_nxt;
      best_r <= best_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bcls_r <= bcls_nxt;
    if (accept) begin
      cx_r <= cx_nxt;
      cy_r <= cy_nxt;
      w_r  <= w_nxt;
      h_r  <= h_nxt;
    end
  end

endmodule

/* design/drd_queue.sv */
// Short register queue of qualified rows between front and back parts.
// Depends on drd_pkg for the row record type.
module drd_queue
  import drd_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  row_rec_t push_rec,
  input  logic     pop,
  output row_rec_t head,
  output q_stat_t  q_stat
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);
  localparam logic [PTR_W-1:0] PTR_ONE = PTR_W'(1);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  row_rec_t         mem_r [DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_pop;

  assign do_pop           = pop && (cnt_r != '0);
  assign head             = mem_r[rd_r];
  assign q_stat.full      = (cnt_r == FULL);
  assign q_stat.not_empty = (cnt_r != '0);

  always_comb begin
    wr_nxt  = push   ? ((wr_r == LAST) ? '0 : wr_r + PTR_ONE) : wr_r;
    rd_nxt  = do_pop ? ((rd_r == LAST) ? '0 : rd_r + PTR_ONE) : rd_r;
    cnt_nxt = cnt_r;
    case ({push, do_pop})
      2'b10:   cnt_nxt = cnt_r + CNT_ONE;
      2'b01:   cnt_nxt = cnt_r - CNT_ONE;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_rec;
    end
  end

endmodule

/* design/drd_back.sv */
// Back part: scales a queued row to pixels, clips it, drives the result port.
// Depends on drd_pkg; pops rows from drd_queue.
module drd_back
  import drd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  row_rec_t         head,
  input  q_stat_t          q_stat,
  output logic             pop,
  input  logic [PIX_W-1:0] frame_w,
  input  logic [PIX_W-1:0] frame_h,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [CLS_W-1:0] out_class_index,
  output logic [VAL_W-1:0] out_score,
  output logic [PIX_W-1:0] out_box_left,
  output logic [PIX_W-1:0] out_box_top,
  output logic [PIX_W-1:0] out_box_width,
  output logic [PIX_W-1:0] out_box_height
);

  // Stage 1: products.
  logic             s1_valid_r;
  logic [CLS_W-1:0] s1_cls_r;
  logic [VAL_W-1:0] s1_score_r;
  logic             s1_lpos_r, s1_tpos_r;
  logic [28:0]      s1_lp_r, s1_tp_r;
  logic [27:0]      s1_wp_r, s1_hp_r;

  logic [17:0]      xnum, ynum;
  logic             out_load, s1_load;

  // Stage 2: clip and keep.
  logic [PIX_W-1:0] left, top, wsz, hsz, wroom, hroom, bw, bh;
  logic             keep;

  logic             out_valid_r;
  logic [CLS_W-1:0] out_cls_r;
  logic [VAL_W-1:0] out_score_r;
  logic [PIX_W-1:0] out_left_r, out_top_r, out_w_r, out_h_r;

  assign out_load = !out_valid_r || !out_stall;
  assign s1_load  = !s1_valid_r || out_load;
  assign pop      = s1_load && q_stat.not_empty;

  assign xnum = {1'b0, head.cx, 1'b0} - {2'b00, head.w_frac};
  assign ynum = {1'b0, head.cy, 1'b0} - {2'b00, head.h_frac};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= q_stat.not_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_cls_r   <= head.class_idx;
      s1_score_r <= head.score;
      s1_lpos_r  <= !xnum[17] && (xnum[16:0] != '0);
      s1_tpos_r  <= !ynum[17] && (ynum[16:0] != '0);
      s1_lp_r    <= 29'(xnum[16:0]) * 29'(frame_w);
      s1_tp_r    <= 29'(ynum[16:0]) * 29'(frame_h);
      s1_wp_r    <= 28'(head.w_frac) * 28'(frame_w);
      s1_hp_r    <= 28'(head.h_frac) * 28'(frame_h);
    end
  end

  always_comb begin
    left  = s1_lpos_r ? s1_lp_r[28:17] : '0;
    top   = s1_tpos_r ? s1_tp_r[28:17] : '0;
    wsz   = s1_wp_r[27:16];
    hsz   = s1_hp_r[27:16];
    wroom = frame_w - left;
    hroom = frame_h - top;
    bw    = (wsz < wroom) ? wsz : wroom;
    bh    = (hsz < hroom) ? hsz : hroom;
    keep  = (bw != '0) && (bh != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= s1_valid_r && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_cls_r   <= s1_cls_r;
      out_score_r <= s1_score_r;
      out_left_r  <= left;
      out_top_r   <= top;
      out_w_r     <= bw;
      out_h_r     <= bh;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_class_index = out_cls_r;
  assign out_score       = out_score_r;
  assign out_box_left    = out_left_r;
  assign out_box_top     = out_top_r;
  assign out_box_width   = out_w_r;
  assign out_box_height  = out_h_r;

endmodule

/* design/detection_row_argmax_box_decode_unit.sv */
// Detection row decoder: running class argmax and pixel box conversion.
// Top level; depends on drd_pkg, drd_front, drd_queue and drd_back.
//
// Usage:
//   Input channel (in_valid / in_stall): one row element per transaction.
//   Elements 0..3 are centre x, centre y, width, height (Q0.16 of the frame),
//   later elements are class scores. in_row_end marks the row's last element.
//   Result channel (out_valid / out_stall): at most one detection per row,
//   sent when the best score beats conf_threshold and the clipped box has
//   positive width and height.
//   Throughput: one element per cycle while in_stall is low, rows may follow back to back.
//   The detection passes from the row_end transaction through the queue
//   register, the product stage and then the output register.
//   The queue between the front and back parts holds QUEUE_DEPTH rows; when
//   the receiver stalls, the output register holds, the product stage and
//   queue fill, and in_stall rises only once the queue is full.
//   Reset (rst_n low, synchronous) clears the row position, best score,
//   queue and all valid flags, and loads the register defaults
//   (threshold 32768, frame 640 x 480). Registers: 0 conf_threshold,
//   1 frame_width, 2 frame_height, at byte addresses 0, 4, 8; write only
//   while the block is idle.
module detection_row_argmax_box_decode_unit
  import drd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  // row element input
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [VAL_W-1:0] in_value,
  input  logic             in_row_end,
  // detection output
  output logic             out_valid,
  input  logic             out_stall,
  output logic [CLS_W-1:0] out_class_index,
  output logic [VAL_W-1:0] out_score,
  output logic [PIX_W-1:0] out_box_left,
  output logic [PIX_W-1:0] out_box_top,
  output logic [PIX_W-1:0] out_box_width,
  output logic [PIX_W-1:0] out_box_height,
  // APB-style register port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [VAL_W-1:0] conf_thr_r;
  logic [PIX_W-1:0] frame_w_r, frame_h_r;
  logic             wr_en;
  logic [1:0]       reg_idx;

  logic             push, pop;
  row_rec_t         push_rec, head;
  q_stat_t          q_stat;

  // Register port: always ready, write on the access phase.
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conf_thr_r <= RST_CONF_THR;
      frame_w_r  <= RST_FRAME_W;
      frame_h_r  <= RST_FRAME_H;
    end else if (wr_en) begin
      case (reg_idx)
        REG_CONF_THR: conf_thr_r <= pwdata[VAL_W-1:0];
        REG_FRAME_W:  frame_w_r  <= pwdata[PIX_W-1:0];
        REG_FRAME_H:  frame_h_r  <= pwdata[PIX_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CONF_THR: prdata = {16'b0, conf_thr_r};
      REG_FRAME_W:  prdata = {20'b0, frame_w_r};
      REG_FRAME_H:  prdata = {20'b0, frame_h_r};
      default:      prdata = '0;
    endcase
  end

  // Front: position tracking, argmax, threshold test at row end.
  drd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_value   (in_value),
    .in_row_end (in_row_end),
    .conf_thr   (conf_thr_r),
    .q_stat     (q_stat),
    .push       (push),
    .push_rec   (push_rec)
  );

  // Decouple row arrival from box arithmetic and receiver stalls.
  drd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  // Back: scale to pixels, clamp edges, clip sizes, drop empty boxes.
  drd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .q_stat          (q_stat),
    .pop             (pop),
    .frame_w         (frame_w_r),
    .frame_h         (frame_h_r),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_class_index (out_class_index),
    .out_score       (out_score),
    .out_box_left    (out_box_left),
    .out_box_top     (out_box_top),
    .out_box_width   (out_box_width),
    .out_box_height  (out_box_height)
  );

endmodule

/* design/drd_checker.sv */
// Port-level checker for the detection row decoder, bound to the top level.
// Depends on drd_pkg and detection_row_argmax_box_decode_unit_assert.svh.
`include "detection_row_argmax_box_decode_unit_assert.svh"

module drd_checker
  import drd_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_stall,
  input logic [CLS_W-1:0] out_class_index,
  input logic [VAL_W-1:0] out_score,
  input logic [PIX_W-1:0] out_box_left,
  input logic [PIX_W-1:0] out_box_top,
  input logic [PIX_W-1:0] out_box_width,
  input logic [PIX_W-1:0] out_box_height
);

  logic [CLS_W+VAL_W+4*PIX_W-1:0] out_payload;
  logic                           box_ok;

  assign out_payload = {out_class_index, out_score, out_box_left, out_box_top,
                        out_box_width, out_box_height};
  assign box_ok      = (out_box_width != '0) && (out_box_height != '0);

  // A stalled detection holds its payload.
  `DRD_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_payload))

  // Empty boxes never leave the block.
  `DRD_ASSERT_IMP(a_box_nonempty, clk, rst_n, out_valid, box_ok)

  // A detection always carries a nonzero score.
  `DRD_ASSERT_IMP(a_score_nonzero, clk, rst_n, out_valid, out_score != '0)

  // Reset drops any pending detection.
  `DRD_ASSERT_NXT_RST(a_reset_clears, clk, !rst_n, !out_valid)

endmodule

bind detection_row_argmax_box_decode_unit drd_checker u_drd_checker (.*);

/* dv/tb_detection_row_argmax_box_decode_unit.sv */
// Self-checking testbench for the detection row decoder.
// Depends on drd_pkg and detection_row_argmax_box_decode_unit; reads no files.
// Predicts each row's detection in a ledger class, then compares every result.
module tb_detection_row_argmax_box_decode_unit;
  import drd_pkg::*;

  localparam int CLK_HALF      = 10;
  localparam int RESET_CYCLES  = 9;
  localparam int RANDOM_ITEMS  = 1300;
  localparam int PHASES        = 8;
  localparam int PRESSURE_PH   = 2;
  localparam int PAUSE_PH      = 4;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 400;
  localparam int QUIET_LIMIT   = 3000;
  localparam int REPORT_LIMIT  = 10;

  // One detection as it leaves the block, in port order.
  typedef struct packed {
    logic [CLS_W-1:0] class_index;
    logic [VAL_W-1:0] score;
    logic [PIX_W-1:0] box_left;
    logic [PIX_W-1:0] box_top;
    logic [PIX_W-1:0] box_width;
    logic [PIX_W-1:0] box_height;
  } detection_t;

  // Keeps its own copy of the registers and the open row, predicts the
  // detection each closed row should produce and matches results in order.
  class detection_ledger;
    logic [VAL_W-1:0] threshold;
    logic [PIX_W-1:0] frame_w;
    logic [PIX_W-1:0] frame_h;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] cx;
    logic [VAL_W-1:0] cy;
    logic [VAL_W-1:0] w_frac;
    logic [VAL_W-1:0] h_frac;
    logic [VAL_W-1:0] best_score;
    logic [CLS_W-1:0] best_class;
    detection_t       expected_detections[$];
    int               mismatches;
    int               elements;
    int               rows;
    int               detections;

    function new();
      threshold  = RST_CONF_THR;
      frame_w    = RST_FRAME_W;
      frame_h    = RST_FRAME_H;
      mismatches = 0;
      elements   = 0;
      rows       = 0;
      detections = 0;
      clear_row();
    endfunction

    function void clear_row();
      position   = '0;
      cx         = '0;
      cy         = '0;
      w_frac     = '0;
      h_frac     = '0;
      best_score = '0;
      best_class = '0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_CONF_THR: threshold = val[VAL_W-1:0];
        REG_FRAME_W:  frame_w   = val[PIX_W-1:0];
        REG_FRAME_H:  frame_h   = val[PIX_W-1:0];
        default: ;
      endcase
    endfunction

    function void check_register(logic [1:0] idx, logic [31:0] got);
      logic [31:0] want;
      case (idx)
        REG_CONF_THR: want = 32'(threshold);
        REG_FRAME_W:  want = 32'(frame_w);
        REG_FRAME_H:  want = 32'(frame_h);
        default:      want = '0;
      endcase
      if (got !== want) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("register %0d readback: expected %0d, got %0d", idx, want, got);
      end
    endfunction

    // Edge pixel: floor((2c - s) * dim / 2^17), zero when the edge is negative.
    function longint edge_pixels(logic [VAL_W-1:0] centre, logic [VAL_W-1:0] size,
                                 logic [PIX_W-1:0] dim);
      longint twice_off;
      twice_off = 2 * longint'(centre) - longint'(size);
      if (twice_off <= 0) return 0;
      return (twice_off * longint'(dim)) >>> 17;
    endfunction

    // Size pixel: floor(s * dim / 2^16), clipped to what is left of the frame.
    function longint size_pixels(logic [VAL_W-1:0] size, logic [PIX_W-1:0] dim,
                                 longint edge_pos);
      longint span;
      longint room;
      span = (longint'(size) * longint'(dim)) >>> 16;
      room = longint'(dim) - edge_pos;
      return (span < room) ? span : room;
    endfunction

    function void note_element(logic [VAL_W-1:0] v, logic last);
      int         cls;
      longint     left;
      longint     top;
      longint     bw;
      longint     bh;
      detection_t d;
      elements++;
      if (position == POS_CX) cx = v;
      else if (position == POS_CY) cy = v;
      else if (position == POS_W_FRAC) w_frac = v;
      else if (position == POS_H_FRAC) h_frac = v;
      else if (position != POS_SAT) begin
        cls = int'(position) - int'(POS_FIRST_SCORE);
        if (cls < int'(MAX_CLASSES) && v > best_score) begin
          best_score = v;
          best_class = cls[CLS_W-1:0];
        end
      end
      if (position != POS_SAT) position++;
      if (last) begin
        rows++;
        if (best_score > threshold) begin
          left = edge_pixels(cx, w_frac, frame_w);
          top  = edge_pixels(cy, h_frac, frame_h);
          bw   = size_pixels(w_frac, frame_w, left);
          bh   = size_pixels(h_frac, frame_h, top);
          if (bw > 0 && bh > 0) begin
            d.class_index = best_class;
            d.score       = best_score;
            d.box_left    = left[PIX_W-1:0];
            d.box_top     = top[PIX_W-1:0];
            d.box_width   = bw[PIX_W-1:0];
            d.box_height  = bh[PIX_W-1:0];
            expected_detections.insert(expected_detections.size(), d);
          end
        end
        clear_row();
      end
    endfunction

    function void check_detection(detection_t got);
      detection_t want;
      if (expected_detections.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected detection: class %0d score %0d box %0d,%0d %0dx%0d",
                   got.class_index, got.score, got.box_left, got.box_top,
                   got.box_width, got.box_height);
        return;
      end
      want = expected_detections.pop_front();
      detections++;
      if (got.class_index !== want.class_index || got.score !== want.score ||
          got.box_left !== want.box_left || got.box_top !== want.box_top ||
          got.box_width !== want.box_width || got.box_height !== want.box_height) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("detection %0d expected: class %0d score %0d box %0d,%0d %0dx%0d",
                   detections, want.class_index, want.score, want.box_left,
                   want.box_top, want.box_width, want.box_height);
          $display("detection %0d actual:   class %0d score %0d box %0d,%0d %0dx%0d",
                   detections, got.class_index, got.score, got.box_left,
                   got.box_top, got.box_width, got.box_height);
        end
      end
    endfunction

    function int pending();
      return expected_detections.size();
    endfunction
  endclass

  logic             clk;
  logic             rst_n      = 1'b0;
  logic             in_valid   = 1'b0;
  logic             in_stall;
  logic [VAL_W-1:0] in_value   = '0;
  logic             in_row_end = 1'b0;
  logic             out_valid;
  logic             out_stall  = 1'b0;
  logic [CLS_W-1:0] out_class_index;
  logic [VAL_W-1:0] out_score;
  logic [PIX_W-1:0] out_box_left;
  logic [PIX_W-1:0] out_box_top;
  logic [PIX_W-1:0] out_box_width;
  logic [PIX_W-1:0] out_box_height;
  logic             psel       = 1'b0;
  logic             penable    = 1'b0;
  logic             pwrite     = 1'b0;
  logic [3:0]       paddr      = '0;
  logic [31:0]      pwdata     = '0;
  logic [31:0]      prdata;
  logic             pready;

  // Idling switch and hold-off request, both owned by the stimulus process.
  logic             idle_on    = 1'b1;
  logic             hold_token = 1'b0;
  // Receiver-side bookkeeping, owned by the result process.
  logic             hold_seen  = 1'b0;
  int               hold_left  = 0;
  int               burst_left = 0;

  detection_ledger  ledger;
  logic [VAL_W-1:0] row_buf[$];
  int               settings_used = 0;

  detection_row_argmax_box_decode_unit u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_value        (in_value),
    .in_row_end      (in_row_end),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_class_index (out_class_index),
    .out_score       (out_score),
    .out_box_left    (out_box_left),
    .out_box_top     (out_box_top),
    .out_box_width   (out_box_width),
    .out_box_height  (out_box_height),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Result side: check each accepted transaction, then pick the next stall.
  // A toggle of hold_token starts a long hold-off that is counted here.
  always @(posedge clk) begin : result_sink
    detection_t got;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      got = {out_class_index, out_score, out_box_left, out_box_top,
             out_box_width, out_box_height};
      ledger.check_detection(got);
    end
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (burst_left > 0) begin
      burst_left--;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 11) == 0) begin
      burst_left = $urandom_range(1, 16) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: end the run when no transaction of any kind moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  // Append one element to the row being built.
  function automatic void add_element(input logic [VAL_W-1:0] v);
    row_buf.insert(row_buf.size(), v);
  endfunction

  // Offer one element and hold it until accepted; maybe idle afterwards.
  // Leave in_valid high when no gap follows so back-to-back items stay clean.
  task automatic send_element(input logic [VAL_W-1:0] v, input logic last);
    in_valid   <= 1'b1;
    in_value   <= v;
    in_row_end <= last;
    do @(posedge clk); while (in_stall !== 1'b0);
    ledger.note_element(v, last);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // Send row_buf as one row, row_end on its last element.
  task automatic send_row();
    foreach (row_buf[i])
      send_element(row_buf[i], i == row_buf.size() - 1);
  endtask

  // Stop offering, wait for every predicted detection, then let rows that
  // are dropped late in the pipe clear out before anything else happens.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register, then read it straight back while psel stays high.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    ledger.set_reg(idx, val);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    ledger.check_register(idx, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic configure(input logic [VAL_W-1:0] thr, input logic [PIX_W-1:0] fw,
                           input logic [PIX_W-1:0] fh);
    write_reg(REG_CONF_THR, 32'(thr));
    write_reg(REG_FRAME_W, 32'(fw));
    write_reg(REG_FRAME_H, 32'(fh));
    settings_used++;
  endtask

  // Box fields: mostly full-range, sometimes a centered box of moderate size.
  task automatic push_box();
    if ($urandom_range(0, 3) == 0) begin
      add_element(16'($urandom_range(16'h4000, 16'hC000)));
      add_element(16'($urandom_range(16'h4000, 16'hC000)));
      add_element(16'($urandom_range(16'h0800, 16'h6000)));
      add_element(16'($urandom_range(16'h0800, 16'h6000)));
    end else begin
      repeat (4) add_element(16'($urandom_range(0, 16'hFFFF)));
    end
  endtask

  // Mostly well-formed rows with random scores; the rest are rows that end
  // inside the box, rows of tied or zero scores, and rows past MAX_CLASSES.
  task automatic fill_random_row();
    int               kind;
    logic [VAL_W-1:0] tie;
    row_buf.delete();
    kind = $urandom_range(0, 99);
    if (kind < 80) begin
      push_box();
      repeat ($urandom_range(1, 20)) add_element(16'($urandom_range(0, 16'hFFFF)));
    end else if (kind < 90) begin
      repeat ($urandom_range(1, 4)) add_element(16'($urandom_range(0, 16'hFFFF)));
    end else if (kind < 98) begin
      push_box();
      tie = ($urandom_range(0, 2) == 0) ? '0 : 16'($urandom_range(0, 16'hFFFF));
      repeat ($urandom_range(2, 12)) add_element(tie);
    end else begin
      push_box();
      repeat ($urandom_range(120, 136)) add_element(16'($urandom_range(0, 16'hFFFF)));
    end
  endtask

  initial begin : stimulus
    int               ph;
    int               target;
    logic [VAL_W-1:0] thr;
    logic [PIX_W-1:0] fw;
    logic [PIX_W-1:0] fh;
    ledger = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows at the reset settings (threshold half scale, 640 x 480).
    // Ties keep the first of two equal top scores.
    row_buf = '{16'h8000, 16'h8000, 16'h4000, 16'h4000,
                16'h1000, 16'hFFFF, 16'hFFFF, 16'h8000};
    send_row();
    // Box hanging off the top-left corner: both edges clamp to zero.
    row_buf = '{16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h8001};
    send_row();
    // Score equal to the threshold does not pass.
    row_buf = '{16'h8000, 16'h8000, 16'h4000, 16'h4000, 16'h8000};
    send_row();
    // Rows that close before any score arrives.
    row_buf = '{16'h8000, 16'h8000, 16'h4000};
    send_row();
    row_buf = '{16'hFFFF};
    send_row();
    // Width below one pixel: nothing leaves the block.
    row_buf = '{16'hFFFF, 16'h8000, 16'h0001, 16'h4000, 16'hFFFF};
    send_row();
    // Every field at full scale: size clips to the frame edge.
    row_buf = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
    send_row();
    // All-zero scores never beat the starting best of zero.
    row_buf = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h0000};
    send_row();
    // Over-long row: the last valid class wins, higher scores past it are
    // dropped, and the position saturates before row_end arrives.
    row_buf = '{16'h8000, 16'h8000, 16'h2000, 16'h2000};
    repeat (127) add_element(16'h1234);
    add_element(16'hF000);
    repeat (132) add_element(16'hFFFF);
    send_row();

    // Random phases, each at its own register setting written while idle.
    target = ledger.elements;
    for (ph = 0; ph < PHASES; ph++) begin
      drain_results();
      case (ph)
        0: begin thr = '0;       fw = 12'd4095; fh = 12'd4095; end
        1: begin thr = 16'hFFFF; fw = 12'd1;    fh = 12'd1;    end
        PRESSURE_PH: begin
          thr = 16'($urandom_range(0, 16'h1000));
          fw  = 12'($urandom_range(200, 4095));
          fh  = 12'($urandom_range(200, 4095));
        end
        default: begin
          thr = 16'($urandom_range(0, 16'hC000));
          fw  = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(1, 64))
                                            : 12'($urandom_range(1, 4095));
          fh  = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(1, 64))
                                            : 12'($urandom_range(1, 4095));
        end
      endcase
      configure(thr, fw, fh);
      // Drop all idling for the closing stretch.
      if (ph == PHASES - 1) idle_on <= 1'b0;
      target += RANDOM_ITEMS / PHASES;
      while (ledger.elements < target) begin
        fill_random_row();
        send_row();
        // Hold the result side off early in the phase while rows keep
        // coming, so the queue fills and the input stalls.
        if (ph == PRESSURE_PH && hold_token == hold_seen && hold_left == 0)
          hold_token <= ~hold_token;
        // Pause the sender whenever the row count is a multiple of 16, until every detection is out.
        if (ph == PAUSE_PH && ledger.rows % 16 == 0)
          drain_results();
      end
    end
    drain_results();

    $display("Sent %0d row elements in %0d rows over %0d register settings;",
             ledger.elements, ledger.rows, settings_used + 1);
    $display("%0d detections checked, with a long output hold-off, sender pauses",
             ledger.detections);
    $display("and an idle-free final stretch.");
    if (ledger.mismatches == 0 && ledger.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d detections still expected", ledger.mismatches,
               ledger.pending());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* detection_row_argmax_box_decode_unit.f */
+incdir+design
design/drd_pkg.sv
design/drd_front.sv
design/drd_queue.sv
design/drd_back.sv
design/detection_row_argmax_box_decode_unit.sv
design/drd_checker.sv
dv/tb_detection_row_argmax_box_decode_unit.sv
